FILE: hdl/wdlps_pkg.sv
// Shared constants, types and the fixed window contents of the pitch shifter.
// No dependencies; every other file of the block imports this package.
package wdlps_pkg;

  localparam int BUFFER_DEPTH = 4096;
  localparam int GRAIN_SIZE   = 1024;
  localparam int SAMPLE_BITS  = 24;
  localparam int FRAC_BITS    = 16;

  localparam int ADDR_BITS  = $clog2(BUFFER_DEPTH);
  localparam int GRAIN_BITS = $clog2(GRAIN_SIZE);
  localparam int POS_W      = ADDR_BITS + FRAC_BITS;

  localparam int RATIO_BITS = 18;
  localparam int BAL_BITS   = 17;
  localparam int FB_BITS    = 16;
  localparam int WIN_BITS   = 16;
  localparam int GAIN_FRAC  = 16;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;

  localparam int MAC_A_W = (SAMPLE_BITS + 2 > RATIO_BITS) ? SAMPLE_BITS + 2 : RATIO_BITS + 1;
  localparam int MAC_B_W = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
  localparam int ACC_W   = MAC_A_W + MAC_B_W + 1;

  localparam int STEP_SHL = (FRAC_BITS >= GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
  localparam int STEP_SHR = (FRAC_BITS >= GAIN_FRAC) ? 0 : GAIN_FRAC - FRAC_BITS;

  localparam logic [RATIO_BITS-1:0] RATIO_ONE  = RATIO_BITS'(65536);
  localparam logic [15:0]           RATIO_KEEP = 16'd62259;
  localparam logic [15:0]           RATIO_MOVE = 16'd3277;
  localparam logic [FB_BITS-1:0]    FB_CAP     = 16'd45875;
  localparam logic [BAL_BITS-1:0]   FULL_WET   = 17'd65536;
  localparam logic [BAL_BITS-1:0]   BAL_RESET  = 17'd32768;

  localparam logic [ACC_W-1:0] HALF_GAIN = ACC_W'(1) << (GAIN_FRAC - 1);
  localparam logic [ACC_W-1:0] HALF_FRAC = ACC_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET,
    CFG_BALANCE,
    CFG_FEEDBACK,
    CFG_BYPASS
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAT0,
    S_RAT1,
    S_RD0,
    S_RD1,
    S_INT,
    S_WIN,
    S_FB,
    S_MIX0,
    S_MIX1,
    S_DONE
  } state_t;

  typedef struct packed {
    logic en;
    logic load;
  } mac_ctrl_t;

  typedef logic [WIN_BITS-1:0] win_rom_t [GRAIN_SIZE];

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam int          WIN_DEN = GRAIN_SIZE - 1;

  // Squared sine by a ninth-order series in Q30, evaluated at elaboration.
  function automatic win_rom_t build_window();
    win_rom_t    t;
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] z;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] w;
    for (int i = 0; i < GRAIN_SIZE; i++) begin
      m = (i < WIN_DEN - i) ? 64'(i) : 64'(WIN_DEN - i);
      a = (PI_Q30 * m) / WIN_DEN;
      z = (a * a) >> 30;
      h = Q30_ONE - z / 72;
      h = Q30_ONE - ((z * h) >> 30) / 42;
      h = Q30_ONE - ((z * h) >> 30) / 20;
      h = Q30_ONE - ((z * h) >> 30) / 6;
      s = (a * h) >> 30;
      w = (s * s + (64'd1 << 43)) >> 44;
      t[i] = (w > 64'd65535) ? 16'hFFFF : w[15:0];
    end
    return t;
  endfunction

  localparam win_rom_t WINDOW_ROM = build_window();

endpackage

FILE: hdl/wdlps_mac.sv
// Shared signed multiply-accumulate unit with a loadable rounding bias.
// Depends on wdlps_pkg for operand widths and the control struct.
module wdlps_mac (
  input  logic                               clk,
  input  wdlps_pkg::mac_ctrl_t               ctrl,
  input  logic        [wdlps_pkg::ACC_W-1:0]   bias,
  input  logic signed [wdlps_pkg::MAC_A_W-1:0] op_a,
  input  logic signed [wdlps_pkg::MAC_B_W-1:0] op_b,
  output logic signed [wdlps_pkg::ACC_W-1:0]   acc
);
  import wdlps_pkg::*;

  logic signed [MAC_A_W+MAC_B_W-1:0] prod;
  logic signed [ACC_W-1:0]           acc_r;
  logic signed [ACC_W-1:0]           acc_nxt;

  assign prod = op_a * op_b;

  always_comb begin
    acc_nxt = (ctrl.load ? $signed(bias) : acc_r) + ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

FILE: hdl/wdlps_ring.sv
// Sample ring: one write port and one registered read port.
// Depends on wdlps_pkg for depth and sample width.
module wdlps_ring (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic        [wdlps_pkg::ADDR_BITS-1:0]   waddr,
  input  logic signed [wdlps_pkg::SAMPLE_BITS-1:0] wdata,
  input  logic                                 re,
  input  logic        [wdlps_pkg::ADDR_BITS-1:0]   raddr,
  output logic signed [wdlps_pkg::SAMPLE_BITS-1:0] rdata
);
  import wdlps_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem [BUFFER_DEPTH];
  logic signed [SAMPLE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/wdlps_window.sv
// Hann window ROM with a registered read.
// Depends on wdlps_pkg for the table contents.
module wdlps_window (
  input  logic                             clk,
  input  logic                             re,
  input  logic [wdlps_pkg::GRAIN_BITS-1:0] addr,
  output logic [wdlps_pkg::WIN_BITS-1:0]   data
);
  import wdlps_pkg::*;

  logic [WIN_BITS-1:0] data_r;

  always_ff @(posedge clk) begin
    if (re) begin
      data_r <= WINDOW_ROM[addr];
    end
  end

  assign data = data_r;

endmodule

FILE: hdl/windowed_delay_line_pitch_shifter.sv
// Pitch shifter top level: sequencer, state and configuration registers.
// Each beat runs the ratio steps (block start only), reads, interpolation, window, feedback
// and mix, or goes straight to hand-over in bypass; no new beat is taken until it is handed
// over. The single shared multiply-accumulate unit and single ring read port set the pace.
// Reset (rst_n, synchronous, active low): pointers zero, ratio one, ring reads as zero
// until written (tracked by a fill flag, no clearing pass), registers at their defaults.
module windowed_delay_line_pitch_shifter (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [wdlps_pkg::SAMPLE_BITS-1:0]  in_sample_in,
  input  logic                                      in_block_start,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [wdlps_pkg::SAMPLE_BITS-1:0]  out_sample_out,
  input  logic                                      cfg_we,
  input  logic        [wdlps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [wdlps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wdlps_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int F  = FRAC_BITS;
  localparam int G  = GAIN_FRAC;

  // configuration registers
  logic [RATIO_BITS-1:0] target_r;
  logic [BAL_BITS-1:0]   balance_r;
  logic [FB_BITS-1:0]    feedback_r;
  logic                  bypass_r;

  // control state
  state_t                state_r;
  state_t                state_nxt;
  logic                  out_valid_r;
  logic [ADDR_BITS-1:0]  wp_r;
  logic [POS_W-1:0]      rp_r;
  logic [RATIO_BITS-1:0] cur_r;
  logic                  full_r;

  // payload
  logic signed [S-1:0]   dry_r;
  logic                  bs_r;
  logic signed [S:0]     wet_r;
  logic                  v_r;
  logic signed [S-1:0]   out_sample_r;

  logic                  accept;
  logic                  can_load;

  // read position pieces
  logic [ADDR_BITS-1:0]  idx;
  logic [ADDR_BITS-1:0]  idx1;
  logic [F-1:0]          frac;
  logic [F:0]            one_minus_frac;
  logic [ADDR_BITS+GRAIN_BITS-1:0] idx_ext;
  logic [POS_W+RATIO_BITS-1:0]     step_wide;
  logic [POS_W-1:0]      step;

  // gains after clamping
  logic [BAL_BITS-1:0]   bal_cl;
  logic [BAL_BITS-1:0]   dry_share;
  logic [FB_BITS-1:0]    fb_cl;
  logic [FB_BITS:0]      fb_coef;

  // shared unit and memories
  mac_ctrl_t                   mac_ctrl;
  logic        [ACC_W-1:0]     mac_bias;
  logic signed [MAC_A_W-1:0]   mac_a;
  logic signed [MAC_B_W-1:0]   mac_b;
  logic signed [ACC_W-1:0]     acc;
  logic                        ring_re;
  logic        [ADDR_BITS-1:0] ring_raddr;
  logic signed [S-1:0]         ring_rdata;
  logic signed [S-1:0]         s_rd;
  logic                        win_re;
  logic        [WIN_BITS-1:0]  win_data;

  logic signed [S-1:0]   interp;
  logic signed [S-1:0]   wet;
  logic signed [S+1:0]   mix;
  logic signed [S-1:0]   mix_sat;

  localparam logic signed [S+1:0] MIX_HI = {3'b000, {(S-1){1'b1}}};
  localparam logic signed [S+1:0] MIX_LO = {3'b111, {(S-1){1'b0}}};

  // hold off the input while reset is applied
  assign in_ready       = rst_n && (state_r == S_IDLE);
  assign accept         = in_valid && in_ready;
  assign can_load       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  assign idx            = rp_r[POS_W-1:F];
  assign idx1           = idx + ADDR_BITS'(1);
  assign frac           = rp_r[F-1:0];
  assign one_minus_frac = {1'b1, {F{1'b0}}} - {1'b0, frac};
  assign idx_ext        = {{GRAIN_BITS{1'b0}}, idx};
  assign step_wide      = ({{POS_W{1'b0}}, cur_r} << STEP_SHL) >> STEP_SHR;
  assign step           = step_wide[POS_W-1:0];

  assign bal_cl    = (balance_r > FULL_WET) ? FULL_WET : balance_r;
  assign dry_share = FULL_WET - bal_cl;
  assign fb_cl     = (feedback_r > FB_CAP) ? FB_CAP : feedback_r;
  // wet + round(wet*fb) folds into one product: wet * (1 + fb), rounded once
  assign fb_coef   = {1'b1, {FB_BITS{1'b0}}} + {1'b0, fb_cl};

  // never-written ring entries read as zero
  assign s_rd    = v_r ? ring_rdata : '0;
  assign interp  = $signed(acc[F+S-1:F]);
  assign wet     = $signed(acc[G+S-1:G]);
  assign mix     = $signed(acc[G+S+1:G]);
  assign mix_sat = (mix > MIX_HI) ? MIX_HI[S-1:0] :
                   (mix < MIX_LO) ? MIX_LO[S-1:0] : mix[S-1:0];

  wdlps_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .bias (mac_bias),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  wdlps_ring u_ring (
    .clk   (clk),
    .we    (accept && !bypass_r),
    .waddr (wp_r),
    .wdata (in_sample_in),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  wdlps_window u_window (
    .clk  (clk),
    .re   (win_re),
    .addr (idx_ext[GRAIN_BITS-1:0]),
    .data (win_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (bypass_r) begin
            state_nxt = S_DONE;
          end else if (in_block_start) begin
            state_nxt = S_RAT0;
          end else begin
            state_nxt = S_RD0;
          end
        end
      end
      S_RAT0: state_nxt = S_RAT1;
      S_RAT1: state_nxt = S_RD0;
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_INT;
      S_INT:  state_nxt = S_WIN;
      S_WIN:  state_nxt = S_FB;
      S_FB:   state_nxt = S_MIX0;
      S_MIX0: state_nxt = S_MIX1;
      S_MIX1: state_nxt = S_DONE;
      S_DONE: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: operand routing for the shared unit, memory reads
  always_comb begin
    mac_ctrl   = '0;
    mac_bias   = HALF_GAIN;
    mac_a      = '0;
    mac_b      = '0;
    ring_re    = 1'b0;
    ring_raddr = idx;
    win_re     = 1'b0;
    case (state_r)
      S_RAT0: begin
        mac_ctrl = '{en: 1'b1, load: 1'b1};
        mac_a    = $signed({{(MAC_A_W-RATIO_BITS){1'b0}}, cur_r});
        mac_b    = $signed({{(MAC_B_W-16){1'b0}}, RATIO_KEEP});
      end
      S_RAT1: begin
        mac_ctrl = '{en: 1'b1, load: 1'b0};
        mac_a    = $signed({{(MAC_A_W-RATIO_BITS){1'b0}}, target_r});
        mac_b    = $signed({{(MAC_B_W-16){1'b0}}, RATIO_MOVE});
      end
      S_RD0: begin
        ring_re = 1'b1;
        win_re  = 1'b1;
      end
      S_RD1: begin
        ring_re    = 1'b1;
        ring_raddr = idx1;
        mac_ctrl   = '{en: 1'b1, load: 1'b1};
        mac_bias   = HALF_FRAC;
        mac_a      = $signed({{(MAC_A_W-S){s_rd[S-1]}}, s_rd});
        mac_b      = $signed({{(MAC_B_W-F-1){1'b0}}, one_minus_frac});
      end
      S_INT: begin
        mac_ctrl = '{en: 1'b1, load: 1'b0};
        mac_a    = $signed({{(MAC_A_W-S){s_rd[S-1]}}, s_rd});
        mac_b    = $signed({{(MAC_B_W-F){1'b0}}, frac});
      end
      S_WIN: begin
        mac_ctrl = '{en: 1'b1, load: 1'b1};
        mac_a    = $signed({{(MAC_A_W-S){interp[S-1]}}, interp});
        mac_b    = $signed({{(MAC_B_W-WIN_BITS){1'b0}}, win_data});
      end
      S_FB: begin
        mac_ctrl = '{en: 1'b1, load: 1'b1};
        mac_a    = $signed({{(MAC_A_W-S){wet[S-1]}}, wet});
        mac_b    = $signed({{(MAC_B_W-FB_BITS-1){1'b0}}, fb_coef});
      end
      S_MIX0: begin
        mac_ctrl = '{en: 1'b1, load: 1'b1};
        mac_a    = $signed({{(MAC_A_W-S){dry_r[S-1]}}, dry_r});
        mac_b    = $signed({{(MAC_B_W-BAL_BITS){1'b0}}, dry_share});
      end
      S_MIX1: begin
        mac_ctrl = '{en: 1'b1, load: 1'b0};
        mac_a    = $signed({{(MAC_A_W-S-1){wet_r[S]}}, wet_r});
        mac_b    = $signed({{(MAC_B_W-BAL_BITS){1'b0}}, bal_cl});
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wp_r        <= '0;
      rp_r        <= '0;
      cur_r       <= RATIO_ONE;
      full_r      <= 1'b0;
      target_r    <= RATIO_ONE;
      balance_r   <= BAL_RESET;
      feedback_r  <= '0;
      bypass_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TARGET:   target_r   <= cfg_data[RATIO_BITS-1:0];
          CFG_BALANCE:  balance_r  <= cfg_data[BAL_BITS-1:0];
          CFG_FEEDBACK: feedback_r <= cfg_data[FB_BITS-1:0];
          CFG_BYPASS:   bypass_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // once the last entry is written the whole ring holds real samples
      if (accept && !bypass_r && (wp_r == {ADDR_BITS{1'b1}})) begin
        full_r <= 1'b1;
      end

      // glide the ratio: the accumulator holds the blend after the second ratio step
      if ((state_r == S_RD0) && bs_r) begin
        cur_r <= acc[G+RATIO_BITS-1:G];
      end

      // advance both pointers once the reads of this beat are done
      if (state_r == S_MIX1) begin
        wp_r <= wp_r + ADDR_BITS'(1);
        rp_r <= rp_r + step;
      end

      if ((state_r == S_DONE) && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      dry_r <= in_sample_in;
      bs_r  <= in_block_start;
    end
    // entries up to the write pointer are filled until the first wrap
    if (state_r == S_RD0) begin
      v_r <= full_r || (idx <= wp_r);
    end else if (state_r == S_RD1) begin
      v_r <= full_r || (idx1 <= wp_r);
    end
    if (state_r == S_MIX0) begin
      wet_r <= $signed(acc[G+S:G]);
    end
    if ((state_r == S_DONE) && can_load) begin
      out_sample_r <= bypass_r ? dry_r : mix_sat;
    end
  end

  // a new result only ever comes out of the hand-over state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output beat raised outside the hand-over state");

  // an accepted beat always starts work
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted beat left the sequencer idle");

  // read position moves only at the end of a processed beat
  a_rp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_MIX1) |=> $stable(rp_r))
    else $error("read position moved outside its update step");

  // bypass holds the write pointer and goes straight to the hand-over state
  a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && bypass_r) |=> $stable(wp_r) && (state_r == S_DONE))
    else $error("bypass beat disturbed the ring state");

endmodule
